/* rtl/idxa_pkg.sv */
package idxa_pkg;

	localparam int CAPACITY = 1024;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = IDX_W + 1;
	localparam int SLOT_W = 12;
	localparam int OP_W = 2;
	localparam int ST_W = 2;

	localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
	localparam logic [OP_W-1:0] OP_FREE = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd2;
	localparam logic [OP_W-1:0] OP_NOP = 2'd3;

	localparam logic [ST_W-1:0] ST_OK = 2'd0;
	localparam logic [ST_W-1:0] ST_EXHAUSTED = 2'd1;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
	localparam logic [ST_W-1:0] ST_DOUBLE = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic [SLOT_W-1:0] slot_index;
	} req_t;

	typedef struct packed {
		logic [IDX_W-1:0] granted_index;
		logic [ST_W-1:0] status;
		logic is_allocated;
		logic [CNT_W-1:0] live_count;
	} rsp_t;

	typedef struct packed {
		logic we;
		logic [IDX_W-1:0] addr;
		logic data;
	} flag_wr_t;

	typedef struct packed {
		logic we;
		logic [IDX_W-1:0] addr;
		logic [IDX_W-1:0] data;
	} stack_wr_t;

endpackage

/* rtl/index_allocator_free_stack_top.sv */
// Pipeline: a request beat passes the memory read stage, then the result register, before response valid.
// Throughput: one request per cycle while responses are taken; flag and stack reads happen at request accept and
//   are bypassed from the write of the operation committing on the same edge.
// Reset: asynchronous, active low; clears counters, stack depth and pipeline valids,
//   capacity returns to 1024. Flags are qualified by the high-water mark, no clearing pass.
// A capacity write clears counters and stack depth.
module index_allocator_free_stack_top (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input idxa_pkg::req_t req,
	output logic rsp_valid,
	input logic rsp_ready,
	output idxa_pkg::rsp_t rsp,
	input logic cfg_we,
	input logic [idxa_pkg::CNT_W-1:0] cfg_data
);

	localparam logic [idxa_pkg::CNT_W-1:0] CAP_MAX = idxa_pkg::CNT_W'(idxa_pkg::CAPACITY);

	logic [idxa_pkg::CNT_W-1:0] pool_cap_q;
	logic [idxa_pkg::CNT_W-1:0] hw_q;
	logic [idxa_pkg::CNT_W-1:0] depth_q;
	logic [idxa_pkg::CNT_W-1:0] count_q;

	logic s1_valid_q;
	logic [idxa_pkg::OP_W-1:0] s1_op_q;
	logic [idxa_pkg::SLOT_W-1:0] s1_idx_q;

	logic rsp_valid_q;
	idxa_pkg::rsp_t rsp_q;

	logic accept;
	logic s1_adv;
	logic flag_rd;
	logic [idxa_pkg::IDX_W-1:0] stack_rd;
	idxa_pkg::flag_wr_t flag_wr;
	idxa_pkg::stack_wr_t stack_wr;

	logic [idxa_pkg::CNT_W-1:0] cap;
	logic flag_hit;
	logic in_range;
	logic [idxa_pkg::CNT_W-1:0] hw_n;
	logic [idxa_pkg::CNT_W-1:0] depth_n;
	logic [idxa_pkg::CNT_W-1:0] count_n;
	logic [idxa_pkg::CNT_W-1:0] depth_eff;
	logic [idxa_pkg::CNT_W-1:0] depth_top;
	logic fwr_en;
	logic [idxa_pkg::IDX_W-1:0] fwr_addr;
	logic fwr_data;
	logic swr_en;
	idxa_pkg::rsp_t res;

	assign s1_adv = s1_valid_q && (!rsp_valid_q || rsp_ready);
	assign req_ready = !s1_valid_q || s1_adv;
	assign accept = req_valid && req_ready;

	assign cap = (pool_cap_q > CAP_MAX) ? CAP_MAX : pool_cap_q;
	assign in_range = s1_idx_q < {1'b0, cap};
	assign flag_hit = (s1_idx_q < {1'b0, hw_q}) && flag_rd;

	always_comb begin
		hw_n = hw_q;
		depth_n = depth_q;
		count_n = count_q;
		fwr_en = 1'b0;
		fwr_addr = s1_idx_q[idxa_pkg::IDX_W-1:0];
		fwr_data = 1'b0;
		swr_en = 1'b0;
		res.granted_index = '0;
		res.status = idxa_pkg::ST_OK;
		res.is_allocated = 1'b0;
		unique case (s1_op_q)
			idxa_pkg::OP_ALLOC: begin
				if (depth_q != '0) begin
					depth_n = depth_q - idxa_pkg::CNT_W'(1);
					res.granted_index = stack_rd;
					fwr_addr = stack_rd;
					fwr_en = 1'b1;
				end else if (hw_q < cap) begin
					hw_n = hw_q + idxa_pkg::CNT_W'(1);
					res.granted_index = hw_q[idxa_pkg::IDX_W-1:0];
					fwr_addr = hw_q[idxa_pkg::IDX_W-1:0];
					fwr_en = 1'b1;
				end else begin
					res.status = idxa_pkg::ST_EXHAUSTED;
				end
				fwr_data = 1'b1;
				if (fwr_en) begin
					count_n = count_q + idxa_pkg::CNT_W'(1);
				end
			end
			idxa_pkg::OP_FREE: begin
				if (!in_range) begin
					res.status = idxa_pkg::ST_RANGE;
				end else if (!flag_hit) begin
					res.status = idxa_pkg::ST_DOUBLE;
				end else begin
					fwr_en = 1'b1;
					if (depth_q < CAP_MAX) begin
						swr_en = 1'b1;
						depth_n = depth_q + idxa_pkg::CNT_W'(1);
					end
					if (count_q != '0) begin
						count_n = count_q - idxa_pkg::CNT_W'(1);
					end
				end
			end
			idxa_pkg::OP_QUERY: begin
				res.is_allocated = in_range && flag_hit;
			end
			default: begin
			end
		endcase
		res.live_count = count_n;
	end

	assign flag_wr.we = s1_adv && fwr_en;
	assign flag_wr.addr = fwr_addr;
	assign flag_wr.data = fwr_data;

	assign stack_wr.we = s1_adv && swr_en;
	assign stack_wr.addr = depth_q[idxa_pkg::IDX_W-1:0];
	assign stack_wr.data = s1_idx_q[idxa_pkg::IDX_W-1:0];

	// pop address tracks the depth after the committing beat
	assign depth_eff = s1_adv ? depth_n : depth_q;
	assign depth_top = depth_eff - idxa_pkg::CNT_W'(1);

	idxa_flags u_flags (
		.clk(clk),
		.rd_en(accept),
		.rd_addr(req.slot_index[idxa_pkg::IDX_W-1:0]),
		.wr(flag_wr),
		.rd_data(flag_rd)
	);

	idxa_stack u_stack (
		.clk(clk),
		.rd_en(accept),
		.rd_addr(depth_top[idxa_pkg::IDX_W-1:0]),
		.wr(stack_wr),
		.rd_data(stack_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_cap_q <= CAP_MAX;
			hw_q <= '0;
			depth_q <= '0;
			count_q <= '0;
		end else if (cfg_we) begin
			pool_cap_q <= cfg_data;
			hw_q <= '0;
			depth_q <= '0;
			count_q <= '0;
		end else if (s1_adv) begin
			hw_q <= hw_n;
			depth_q <= depth_n;
			count_q <= count_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_op_q <= req.op;
			s1_idx_q <= req.slot_index;
		end
		if (s1_adv) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	// every slot below the high-water mark is either live or on the stack
	a_conserve: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, depth_q} + {1'b0, count_q}) == {1'b0, hw_q})
		else $error("depth plus live count differs from high-water mark");

	a_hw_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hw_q <= CAP_MAX)
		else $error("high-water mark above capacity");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_idx_q) && $stable(s1_op_q)))
		else $error("stalled stage lost its beat");

	a_no_state_change_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(!s1_adv && !cfg_we) |=> ($stable(hw_q) && $stable(depth_q) && $stable(count_q)))
		else $error("pool state changed without a committing beat");

endmodule

/* rtl/idxa_flags.sv */
module idxa_flags (
	input logic clk,
	input logic rd_en,
	input logic [idxa_pkg::IDX_W-1:0] rd_addr,
	input idxa_pkg::flag_wr_t wr,
	output logic rd_data
);

	logic mem_q [idxa_pkg::CAPACITY];
	logic rd_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	// read beside a same-edge write returns the new value
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr.we && (wr.addr == rd_addr)) begin
				rd_q <= wr.data;
			end else begin
				rd_q <= mem_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_q;

endmodule

/* rtl/idxa_stack.sv */
module idxa_stack (
	input logic clk,
	input logic rd_en,
	input logic [idxa_pkg::IDX_W-1:0] rd_addr,
	input idxa_pkg::stack_wr_t wr,
	output logic [idxa_pkg::IDX_W-1:0] rd_data
);

	logic [idxa_pkg::IDX_W-1:0] mem_q [idxa_pkg::CAPACITY];
	logic [idxa_pkg::IDX_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr.we && (wr.addr == rd_addr)) begin
				rd_q <= wr.data;
			end else begin
				rd_q <= mem_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_q;

endmodule

/* tb/index_allocator_free_stack_top_tb.sv */
module index_allocator_free_stack_top_tb;

	import idxa_pkg::*;

	typedef struct packed {
		bit pinned;
		rsp_t want;
	} pin_t;

	typedef struct packed {
		bit is_cfg;
		logic [CNT_W-1:0] cap;
		req_t r;
		bit pinned;
		rsp_t want;
	} row_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;
	logic cfg_we;
	logic [CNT_W-1:0] cfg_data;

	// predicted pool state
	int m_cap;
	logic [IDX_W-1:0] m_stack [CAPACITY];
	bit m_flag [CAPACITY];
	int m_depth;
	int m_high;
	int m_live;

	rsp_t owed_rsp_q [$];
	pin_t pin_q [$];
	row_t rows [$];
	int errors;
	bit req_fired;
	bit calm_req;
	bit calm_rsp;
	int stall_left;
	rsp_t got_rsp;
	rsp_t exp_rsp;
	pin_t cur_pin;

	index_allocator_free_stack_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#6_000_000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic void pool_clear();
		foreach (m_flag[i]) m_flag[i] = 1'b0;
		m_depth = 0;
		m_high = 0;
		m_live = 0;
	endfunction

	function automatic rsp_t pool_apply(req_t r);
		rsp_t o;
		int cap;
		int slot;
		int idx;
		bit have;
		o = '0;
		cap = (m_cap > CAPACITY) ? CAPACITY : m_cap;
		idx = r.slot_index;
		case (r.op)
			OP_ALLOC: begin
				have = 1'b0;
				slot = 0;
				if (m_depth > 0) begin
					m_depth--;
					slot = m_stack[m_depth];
					have = 1'b1;
				end else if (m_high < cap) begin
					slot = m_high;
					m_high++;
					have = 1'b1;
				end
				if (have && slot < cap && !m_flag[slot]) begin
					m_flag[slot] = 1'b1;
					m_live++;
					o.granted_index = IDX_W'(slot);
				end else begin
					o.status = ST_EXHAUSTED;
				end
			end
			OP_FREE: begin
				if (idx >= cap) begin
					o.status = ST_RANGE;
				end else if (!m_flag[idx]) begin
					o.status = ST_DOUBLE;
				end else begin
					m_flag[idx] = 1'b0;
					if (m_depth < CAPACITY) begin
						m_stack[m_depth] = IDX_W'(idx);
						m_depth++;
					end
					if (m_live > 0) m_live--;
				end
			end
			OP_QUERY: begin
				if (idx < cap) o.is_allocated = m_flag[idx];
			end
			default: ;
		endcase
		o.live_count = CNT_W'(m_live);
		return o;
	endfunction

	task automatic report(string what, int got, int want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	always @(posedge clk) begin
		req_fired = req_valid && req_ready;
		if (cfg_we) begin
			m_cap = cfg_data;
			pool_clear();
		end
		if (req_fired) begin
			got_rsp = pool_apply(req);
			cur_pin = pin_q.pop_front();
			owed_rsp_q.push_back(cur_pin.pinned ? cur_pin.want : got_rsp);
		end
		if (arst_n && rsp_valid && rsp_ready) begin
			if (owed_rsp_q.size() == 0) begin
				report("response beat with none outstanding", 1, 0);
			end else begin
				exp_rsp = owed_rsp_q.pop_front();
				if (rsp.granted_index !== exp_rsp.granted_index)
					report("granted_index", rsp.granted_index, exp_rsp.granted_index);
				if (rsp.status !== exp_rsp.status)
					report("status", rsp.status, exp_rsp.status);
				if (rsp.is_allocated !== exp_rsp.is_allocated)
					report("is_allocated", rsp.is_allocated, exp_rsp.is_allocated);
				if (rsp.live_count !== exp_rsp.live_count)
					report("live_count", rsp.live_count, exp_rsp.live_count);
			end
		end
	end

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 85) return $urandom_range(1, 3);
		if (p < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// response side backpressure
	always @(negedge clk) begin
		if ($urandom_range(0, 99) == 0) calm_rsp = !calm_rsp;
		if (stall_left > 0) begin
			rsp_ready <= 1'b0;
			stall_left--;
		end else begin
			rsp_ready <= 1'b1;
			if (!calm_rsp && $urandom_range(0, 99) < 30) stall_left = gap_len();
		end
	end

	function automatic void add_beat(logic [OP_W-1:0] op, int slot, bit pin,
			int g, logic [ST_W-1:0] st, bit fl, int live);
		row_t w;
		w = '0;
		w.r.op = op;
		w.r.slot_index = SLOT_W'(slot);
		w.pinned = pin;
		w.want.granted_index = IDX_W'(g);
		w.want.status = st;
		w.want.is_allocated = fl;
		w.want.live_count = CNT_W'(live);
		rows.push_back(w);
	endfunction

	function automatic void add_cap(int v);
		row_t w;
		w = '0;
		w.is_cfg = 1'b1;
		w.cap = CNT_W'(v);
		rows.push_back(w);
	endfunction

	task automatic send_beat(req_t r, bit pin, rsp_t want);
		int g;
		pin_t p;
		g = calm_req ? 0 : gap_len();
		if (g > 0) begin
			req_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		p.pinned = pin;
		p.want = want;
		pin_q.push_back(p);
		req_valid <= 1'b1;
		req <= r;
		do @(negedge clk); while (!req_fired);
	endtask

	// only between phases, with the pipeline drained
	task automatic set_capacity(int v);
		req_valid <= 1'b0;
		while (owed_rsp_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= CNT_W'(v);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		req_t r;
		int sent;
		int phase;
		int n;
		int k;
		int p;
		int q;
		int cap_v;
		int eff;
		int alloc_pct;

		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		errors = 0;
		req_fired = 1'b0;
		calm_req = 1'b0;
		calm_rsp = 1'b0;
		stall_left = 0;
		m_cap = CAPACITY;
		pool_clear();

		// after reset, pool of 1024
		add_beat(OP_ALLOC, 0, 1, 0, ST_OK, 0, 1);
		add_beat(OP_ALLOC, 0, 1, 1, ST_OK, 0, 2);
		add_beat(OP_QUERY, 1, 1, 0, ST_OK, 1, 2);
		add_beat(OP_QUERY, 4095, 1, 0, ST_OK, 0, 2);
		add_beat(OP_FREE, 4095, 1, 0, ST_RANGE, 0, 2);
		add_beat(OP_FREE, 1024, 1, 0, ST_RANGE, 0, 2);
		add_beat(OP_FREE, 1023, 1, 0, ST_DOUBLE, 0, 2);
		add_beat(OP_FREE, 1, 0, 0, ST_OK, 0, 0);
		add_beat(OP_ALLOC, 0, 0, 0, ST_OK, 0, 0);
		add_beat(OP_NOP, 4095, 1, 0, ST_OK, 0, 2);
		add_beat(OP_FREE, 0, 0, 0, ST_OK, 0, 0);
		add_beat(OP_FREE, 0, 1, 0, ST_DOUBLE, 0, 1);
		// single slot pool
		add_cap(1);
		add_beat(OP_ALLOC, 0, 1, 0, ST_OK, 0, 1);
		add_beat(OP_ALLOC, 0, 1, 0, ST_EXHAUSTED, 0, 1);
		add_beat(OP_FREE, 1, 1, 0, ST_RANGE, 0, 1);
		add_beat(OP_FREE, 0, 0, 0, ST_OK, 0, 0);
		add_beat(OP_QUERY, 0, 0, 0, ST_OK, 0, 0);
		// empty pool
		add_cap(0);
		add_beat(OP_ALLOC, 0, 1, 0, ST_EXHAUSTED, 0, 0);
		add_beat(OP_FREE, 0, 1, 0, ST_RANGE, 0, 0);
		add_beat(OP_QUERY, 0, 1, 0, ST_OK, 0, 0);
		// oversize capacity clamps to the built size
		add_cap(2047);
		add_beat(OP_ALLOC, 0, 1, 0, ST_OK, 0, 1);
		add_beat(OP_QUERY, 1023, 1, 0, ST_OK, 0, 1);
		add_beat(OP_FREE, 2048, 1, 0, ST_RANGE, 0, 1);
		add_beat(OP_FREE, 0, 0, 0, ST_OK, 0, 0);

		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (rows[i]) begin
			if (rows[i].is_cfg) set_capacity(rows[i].cap);
			else send_beat(rows[i].r, rows[i].pinned, rows[i].want);
		end

		sent = 0;
		phase = 0;
		while (sent < 1425) begin
			if (phase == 0) begin
				cap_v = CAPACITY;
				n = 420;
				alloc_pct = 70;
			end else begin
				case ($urandom_range(0, 9))
					0: cap_v = 0;
					1: cap_v = 1;
					2: cap_v = 2;
					3: cap_v = 2047;
					4: cap_v = CAPACITY;
					5: cap_v = $urandom_range(CAPACITY + 1, 2047);
					default: cap_v = $urandom_range(3, 48);
				endcase
				n = $urandom_range(40, 110);
				alloc_pct = $urandom_range(35, 60);
			end
			set_capacity(cap_v);
			eff = (cap_v > CAPACITY) ? CAPACITY : cap_v;
			for (k = 0; k < n; k++) begin
				p = $urandom_range(0, 99);
				r.slot_index = SLOT_W'($urandom);
				if (p < alloc_pct) begin
					r.op = OP_ALLOC;
				end else if (p < 95) begin
					r.op = (p % 3 == 0) ? OP_QUERY : OP_FREE;
					q = $urandom_range(0, 99);
					if (q < 65 && m_high > 0)
						r.slot_index = SLOT_W'($urandom_range(0, m_high - 1));
					else if (q < 88)
						r.slot_index = SLOT_W'($urandom_range(0, eff + 2));
				end else begin
					r.op = OP_NOP;
				end
				if ($urandom_range(0, 79) == 0) calm_req = !calm_req;
				send_beat(r, 1'b0, '0);
			end
			sent += n;
			phase++;
		end
		req_valid <= 1'b0;

		while (owed_rsp_q.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
